// ===== src/double_crystal_ball_eval_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the double-sided Crystal Ball evaluator
// Two checks, one for a same-cycle implication and one for a next-cycle
// implication. Both compile to nothing when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_CRYSTAL_BALL_EVAL_DEFINES_SVH
`define DOUBLE_CRYSTAL_BALL_EVAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DCB_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle check failed");
`define DCB_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");
`else
`define DCB_ASSERT_IMP(label, clk, rst_n, pre, post)
`define DCB_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== src/dcb_pkg.sv =====
// ----------------------------------------------------------------------------
// dcb_pkg
// Beat types, codes and fixed-point constants of the Crystal Ball evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dcb_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int TAYLOR_TERMS   = 24;

    // Lower 32 bits of log2(e) in Q32; the integer part is one.
    localparam logic [31:0] LOG2E_LO = 32'h7154_7652;
    // ln(2) in Q32.
    localparam logic [31:0] LN2_Q32  = 32'hB172_17F7;
    // Base-2 exponent at and above which the result is zero (40.0 in Q32).
    localparam logic [47:0] Y_ZERO   = 48'h0028_0000_0000;
    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [30:0] T_CAP    = 31'h7FFF_FFFF;

    // floor((2^32 - 1) / i) for i = 1 .. 24, used to divide Taylor terms.
    localparam logic [31:0] RECIP_TAB [TAYLOR_TERMS] = '{
        32'd4294967295, 32'd2147483647, 32'd1431655765, 32'd1073741823,
        32'd858993459,  32'd715827882,  32'd613566756,  32'd536870911,
        32'd477218588,  32'd429496729,  32'd390451572,  32'd357913941,
        32'd330382099,  32'd306783378,  32'd286331153,  32'd268435455,
        32'd252645135,  32'd238609294,  32'd226050910,  32'd214748364,
        32'd204522252,  32'd195225786,  32'd186737708,  32'd178956970
    };

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PEAK_MEAN   = 3'd0,
        CFG_CORE_WIDTH  = 3'd1,
        CFG_LEFT_ALPHA  = 3'd2,
        CFG_LEFT_POWER  = 3'd3,
        CFG_RIGHT_ALPHA = 3'd4,
        CFG_RIGHT_POWER = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        REGION_CORE  = 2'd0,
        REGION_LEFT  = 2'd1,
        REGION_RIGHT = 2'd2
    } region_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic signed [31:0] sample_offset;
    } sample_beat_t;

    typedef struct packed {
        logic [31:0] shape_value;
        region_t     region;
    } shape_beat_t;

endpackage

// ===== src/dcb_stream_if.sv =====
// ----------------------------------------------------------------------------
// dcb_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dcb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/double_crystal_ball_eval.sv =====
// ----------------------------------------------------------------------------
// double_crystal_ball_eval
// A sample beat moves through the stage registers from S_IN to S_FIN, the output register.
// Throughput: one sample beat per cycle while the result channel takes its beats; the 146-stage pipeline moves as one.
// Back-pressure on the result channel stalls every stage together.
// Reset clears the stage valid bits and loads the register defaults
// (mean 0, width 1.0, alphas 1.0, powers 2.0); the block is ready at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "double_crystal_ball_eval_defines.svh"

// The shape is computed as 2^-y. The standardized distance t comes from a
// restoring divider with one quotient bit per stage. The core exponent is
// t*t/2 * log2(e); the tail adds n * (log2(W) - log2(V)), each log2 taken by
// 32 squaring stages on two lanes. 2^-y is split into an integer shift and
// e^z with z in (0, ln 2], summed as a 24-term Taylor series at three stages
// per term (multiply, reciprocal multiply, correct and accumulate).
module double_crystal_ball_eval (
    input  logic                                 clk,
    input  logic                                 rst_n,
    dcb_stream_if.sink                           samples,
    dcb_stream_if.source                         results,
    input  logic                                 cfg_we,
    input  logic [dcb_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [dcb_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import dcb_pkg::*;

    // Stage map.
    localparam int S_IN    = 0;
    localparam int S_DIV0  = 1;
    localparam int S_SEL   = 33;
    localparam int S_G1    = 34;
    localparam int S_G2    = 35;
    localparam int S_G3    = 36;
    localparam int S_LOG0  = 37;
    localparam int S_T0    = 69;
    localparam int S_T1    = 70;
    localparam int S_T2    = 71;
    localparam int S_E0    = 72;
    localparam int S_TAY0  = 73;
    localparam int S_FIN   = S_TAY0 + 3 * TAYLOR_TERMS;
    localparam int NSTAGES = S_FIN + 1;

    // Everything one sample carries down the pipeline. Fields that are no
    // longer read past some stage are simply dropped by synthesis.
    typedef struct packed {
        logic        neg;
        logic [30:0] wdt;
        logic [32:0] mag;
        logic        sat;
        logic [30:0] rem;
        logic [30:0] tmag;
        logic        core;
        logic        tailon;
        logic        big;
        logic [23:0] alpha;
        logic [23:0] power;
        logic [18:0] gm;
        logic [30:0] diff;
        logic [36:0] gq;
        logic [62:0] plo;
        logic [35:0] phi;
        logic [37:0] gy;
        logic [55:0] wv;
        logic        hiw;
        logic [4:0]  msbh;
        logic [4:0]  msbl;
        logic [4:0]  msbn;
        logic [5:0]  pw;
        logic [5:0]  pv;
        logic [31:0] mw;
        logic [31:0] mv;
        logic [31:0] fw;
        logic [31:0] fv;
        logic [37:0] dl;
        logic [55:0] ndlo;
        logic [29:0] ndhi;
        logic [47:0] y;
        logic        one;
        logic [5:0]  kexp;
        logic [31:0] z;
        logic [32:0] term;
        logic [31:0] prod;
        logic [31:0] qe;
        logic [34:0] sum;
        logic [31:0] shape;
        region_t     region;
    } stage_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] peak_mean_reg;
    logic [30:0]        core_width_reg;
    logic [23:0]        left_alpha_reg;
    logic [23:0]        left_power_reg;
    logic [23:0]        right_alpha_reg;
    logic [23:0]        right_power_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_mean_reg   <= '0;
            core_width_reg  <= 31'd65536;
            left_alpha_reg  <= 24'd65536;
            left_power_reg  <= 24'd131072;
            right_alpha_reg <= 24'd65536;
            right_power_reg <= 24'd131072;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEAK_MEAN:   peak_mean_reg   <= cfg_data;
                CFG_CORE_WIDTH:  core_width_reg  <= cfg_data[30:0];
                CFG_LEFT_ALPHA:  left_alpha_reg  <= cfg_data[23:0];
                CFG_LEFT_POWER:  left_power_reg  <= cfg_data[23:0];
                CFG_RIGHT_ALPHA: right_alpha_reg <= cfg_data[23:0];
                CFG_RIGHT_POWER: right_power_reg <= cfg_data[23:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage functions
    // ------------------------------------------------------------------

    // Position of the highest set bit (zero for zero).
    function automatic logic [4:0] msb32(input logic [31:0] x);
        logic [4:0] p;
        p = '0;
        for (int k = 0; k < 32; k++)
        begin
            if (x[k])
                p = 5'(k);
        end
        return p;
    endfunction

    // Brings the bit at position p to bit 31 and keeps 32 bits.
    function automatic logic [31:0] norm32(input logic [55:0] x, input logic [5:0] p);
        logic [55:0] s;
        if (p >= 6'd31)
            s = x >> (p - 6'd31);
        else
            s = x << (6'd31 - p);
        return s[31:0];
    endfunction

    // One squaring step of the log2 mantissa: {fraction bit, new mantissa}.
    function automatic logic [32:0] log_sq(input logic [31:0] m);
        logic [63:0] sq;
        logic [32:0] t;
        sq = 64'(m) * 64'(m);
        t  = sq[63:31];
        if (t[32])
            return {1'b1, t[32:1]};
        return {1'b0, t[31:0]};
    endfunction

    function automatic stage_t f_input(input sample_beat_t b, input logic signed [31:0] mean,
                                       input logic [30:0] width);
        stage_t o;
        logic signed [33:0] d;
        o = '0;
        d = 34'(b.sample_value) - 34'(b.sample_offset) - 34'(mean);
        o.neg = d[33];
        o.mag = d[33] ? 33'(-d) : 33'(d);
        o.wdt = (width == 31'd0) ? 31'd1 : width;
        return o;
    endfunction

    // Saturation test and the partial remainder after the quotient bits that
    // are known to be zero.
    function automatic stage_t f_div_init(input stage_t i);
        stage_t o;
        o      = i;
        o.sat  = {13'd0, i.mag} >= {i.wdt, 15'd0};
        o.rem  = {13'd0, i.mag[32:15]};
        o.tmag = '0;
        return o;
    endfunction

    function automatic stage_t f_div_step(input stage_t i, input int b);
        stage_t o;
        logic [31:0] r2;
        logic nb;
        o  = i;
        nb = 1'b0;
        if (b >= 16)
            nb = i.mag[b - 16];
        r2 = {i.rem, nb};
        if (r2 >= {1'b0, i.wdt})
        begin
            o.rem     = 31'(r2 - {1'b0, i.wdt});
            o.tmag[b] = 1'b1;
        end
        else
            o.rem = r2[30:0];
        return o;
    endfunction

    function automatic stage_t f_select(input stage_t i, input logic [23:0] la,
                                        input logic [23:0] lp, input logic [23:0] ra,
                                        input logic [23:0] rp);
        stage_t o;
        logic [30:0] tm;
        logic [30:0] m;
        o        = i;
        tm       = i.sat ? T_CAP : i.tmag;
        o.tmag   = tm;
        o.alpha  = i.neg ? la : ra;
        o.power  = i.neg ? lp : rp;
        o.core   = {7'd0, o.alpha} >= tm;
        m        = o.core ? tm : {7'd0, o.alpha};
        o.big    = |m[30:19];
        o.gm     = m[18:0];
        o.diff   = tm - {7'd0, o.alpha};
        o.tailon = !o.core && (o.power != 24'd0);
        return o;
    endfunction

    function automatic stage_t f_g1(input stage_t i);
        stage_t o;
        logic [37:0] h;
        logic [54:0] wp;
        o    = i;
        h    = 38'(i.gm) * 38'(i.gm);
        o.gq = h[37:1];
        wp   = 55'(i.diff) * 55'(i.alpha);
        o.wv = 56'({i.power, 16'd0}) + 56'(wp);
        return o;
    endfunction

    function automatic stage_t f_g2(input stage_t i);
        stage_t o;
        o      = i;
        o.plo  = 63'(i.gq[31:0]) * 63'(LOG2E_LO);
        o.phi  = 36'(i.gq[36:32]) * 36'(LOG2E_LO);
        o.hiw  = |i.wv[55:32];
        o.msbh = msb32({8'd0, i.wv[55:32]});
        o.msbl = msb32(i.wv[31:0]);
        o.msbn = msb32({8'd0, i.power});
        return o;
    endfunction

    function automatic stage_t f_g3(input stage_t i);
        stage_t o;
        o    = i;
        o.gy = 38'(i.gq) + 38'(i.phi) + 38'(i.plo[62:32]);
        o.pw = i.hiw ? (6'd32 + 6'(i.msbh)) : 6'(i.msbl);
        o.mw = norm32(i.wv, o.pw);
        o.pv = 6'd16 + 6'(i.msbn);
        o.mv = norm32({16'd0, i.power, 16'd0}, o.pv);
        o.fw = '0;
        o.fv = '0;
        return o;
    endfunction

    function automatic stage_t f_log_step(input stage_t i, input int k);
        stage_t o;
        logic [32:0] rw;
        logic [32:0] rv;
        o           = i;
        rw          = log_sq(i.mw);
        rv          = log_sq(i.mv);
        o.mw        = rw[31:0];
        o.mv        = rv[31:0];
        o.fw[31-k]  = rw[32];
        o.fv[31-k]  = rv[32];
        return o;
    endfunction

    function automatic stage_t f_t0(input stage_t i);
        stage_t o;
        logic [37:0] lw;
        logic [37:0] lv;
        o    = i;
        lw   = {i.pw, i.fw};
        lv   = {i.pv, i.fv};
        o.dl = (lw > lv) ? (lw - lv) : '0;
        return o;
    endfunction

    function automatic stage_t f_t1(input stage_t i);
        stage_t o;
        o      = i;
        o.ndlo = 56'(i.power) * 56'(i.dl[31:0]);
        o.ndhi = 30'(i.power) * 30'(i.dl[37:32]);
        return o;
    endfunction

    function automatic stage_t f_t2(input stage_t i);
        stage_t o;
        logic [62:0] nd;
        logic [46:0] e;
        o     = i;
        nd    = 63'({i.ndhi, 32'd0}) + 63'(i.ndlo);
        e     = nd[62:16];
        o.y   = 48'(i.gy) + (i.tailon ? 48'(e) : 48'd0);
        o.big = i.big || (o.y >= Y_ZERO);
        o.one = (o.y == 48'd0);
        return o;
    endfunction

    function automatic stage_t f_e0(input stage_t i);
        stage_t o;
        logic [31:0] fr;
        logic [31:0] s;
        logic [63:0] pz;
        o      = i;
        fr     = i.y[31:0];
        o.kexp = i.y[37:32];
        s      = (~fr) + 32'd1;
        pz     = 64'(s) * 64'(LN2_Q32);
        o.z    = (fr == 32'd0) ? LN2_Q32 : pz[63:32];
        o.term = 33'h1_0000_0000;
        o.sum  = 35'h1_0000_0000;
        return o;
    endfunction

    function automatic stage_t f_tay_mul(input stage_t i);
        stage_t o;
        logic [63:0] pz;
        o      = i;
        pz     = 64'(i.term[31:0]) * 64'(i.z);
        o.prod = i.term[32] ? i.z : pz[63:32];
        return o;
    endfunction

    function automatic stage_t f_tay_recip(input stage_t i, input int k);
        stage_t o;
        logic [63:0] pq;
        o    = i;
        pq   = 64'(i.prod) * 64'(RECIP_TAB[k-1]);
        o.qe = pq[63:32];
        return o;
    endfunction

    // The reciprocal estimate is low by at most one; one compare fixes it.
    function automatic stage_t f_tay_fix(input stage_t i, input int k);
        stage_t o;
        logic [31:0] kk;
        logic [31:0] r;
        logic [31:0] q;
        o      = i;
        kk     = 32'(k);
        r      = i.prod - i.qe * kk;
        q      = (r >= kk) ? (i.qe + 32'd1) : i.qe;
        o.term = {1'b0, q};
        o.sum  = i.sum + 35'(q);
        return o;
    endfunction

    function automatic stage_t f_final(input stage_t i);
        stage_t o;
        logic [6:0]  sh;
        logic [47:0] acc;
        logic [47:0] res;
        o   = i;
        sh  = 7'(i.kexp) + 7'd2;
        acc = 48'(i.sum) + (48'd1 << (sh - 7'd1));
        res = acc >> sh;
        if (i.big)
            o.shape = '0;
        else if (i.one || (res > 48'(ONE_Q31)))
            o.shape = ONE_Q31;
        else
            o.shape = res[31:0];
        if (i.core)
            o.region = REGION_CORE;
        else if (i.neg)
            o.region = REGION_LEFT;
        else
            o.region = REGION_RIGHT;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Pipeline
    // ------------------------------------------------------------------
    stage_t               stage_reg  [NSTAGES];
    stage_t               stage_next [NSTAGES];
    logic [NSTAGES-1:0]   valid_reg;
    logic                 pipe_en;
    logic                 in_acc;
    logic                 out_acc;

    // The final stage is the output register. The whole pipe advances
    // whenever that register is empty or its beat is being taken.
    assign pipe_en       = !valid_reg[S_FIN] || results.ready;
    assign samples.ready = pipe_en;
    assign in_acc        = samples.valid && samples.ready;
    assign out_acc       = results.valid && results.ready;

    for (genvar s = 0; s < NSTAGES; s++)
    begin : g_stage
        if (s == S_IN)
        begin : g_in
            assign stage_next[s] = f_input(samples.data, peak_mean_reg, core_width_reg);
        end
        else if (s == S_DIV0)
        begin : g_div0
            assign stage_next[s] = f_div_init(stage_reg[s-1]);
        end
        else if (s < S_SEL)
        begin : g_div
            assign stage_next[s] = f_div_step(stage_reg[s-1], S_SEL - 1 - s);
        end
        else if (s == S_SEL)
        begin : g_sel
            assign stage_next[s] = f_select(stage_reg[s-1], left_alpha_reg, left_power_reg,
                                            right_alpha_reg, right_power_reg);
        end
        else if (s == S_G1)
        begin : g_g1
            assign stage_next[s] = f_g1(stage_reg[s-1]);
        end
        else if (s == S_G2)
        begin : g_g2
            assign stage_next[s] = f_g2(stage_reg[s-1]);
        end
        else if (s == S_G3)
        begin : g_g3
            assign stage_next[s] = f_g3(stage_reg[s-1]);
        end
        else if (s < S_T0)
        begin : g_log
            assign stage_next[s] = f_log_step(stage_reg[s-1], s - S_LOG0);
        end
        else if (s == S_T0)
        begin : g_t0
            assign stage_next[s] = f_t0(stage_reg[s-1]);
        end
        else if (s == S_T1)
        begin : g_t1
            assign stage_next[s] = f_t1(stage_reg[s-1]);
        end
        else if (s == S_T2)
        begin : g_t2
            assign stage_next[s] = f_t2(stage_reg[s-1]);
        end
        else if (s == S_E0)
        begin : g_e0
            assign stage_next[s] = f_e0(stage_reg[s-1]);
        end
        else if (s < S_FIN)
        begin : g_tay
            localparam int PHASE = (s - S_TAY0) % 3;
            localparam int TERM  = (s - S_TAY0) / 3 + 1;
            if (PHASE == 0)
            begin : g_mul
                assign stage_next[s] = f_tay_mul(stage_reg[s-1]);
            end
            else if (PHASE == 1)
            begin : g_recip
                assign stage_next[s] = f_tay_recip(stage_reg[s-1], TERM);
            end
            else
            begin : g_fix
                assign stage_next[s] = f_tay_fix(stage_reg[s-1], TERM);
            end
        end
        else
        begin : g_fin
            assign stage_next[s] = f_final(stage_reg[s-1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (pipe_en)
            valid_reg <= {valid_reg[NSTAGES-2:0], samples.valid};
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int s = 0; s < NSTAGES; s++)
                stage_reg[s] <= stage_next[s];
        end
    end

    assign results.valid = valid_reg[S_FIN];
    assign results.data  = '{shape_value: stage_reg[S_FIN].shape,
                             region:      stage_reg[S_FIN].region};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A beat taken in with none leaving adds exactly one valid stage.
    `DCB_ASSERT_NXT(a_beat_count, clk, rst_n, (in_acc && !out_acc), ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
    // A stalled pipe keeps its occupancy.
    `DCB_ASSERT_NXT(a_stall_holds, clk, rst_n, (!pipe_en), ($stable(valid_reg)))
    // The shape never exceeds one.
    `DCB_ASSERT_IMP(a_shape_sat, clk, rst_n, (results.valid), (results.data.shape_value <= ONE_Q31))

endmodule

// ===== bench/dcb_shape_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcb_shape_checker
// Watches the sample and result channels and the register write port of the
// Crystal Ball evaluator. It predicts each shape beat in fixed point and
// compares it, in order, with the beats that the block delivers.
// ----------------------------------------------------------------------------

module dcb_shape_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  dcb_pkg::sample_beat_t              s_data,
    input  logic                               r_valid,
    input  logic                               r_ready,
    input  dcb_pkg::shape_beat_t               r_data,
    input  logic                               cfg_we,
    input  logic [dcb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dcb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                 errors,
    output int                                 pending,
    output int                                 checked
);
    import dcb_pkg::*;

    localparam int          FB        = 16;
    localparam logic [63:0] LOG2E_FIX = {32'd1, LOG2E_LO};
    localparam logic [63:0] Y_LIMIT   = {16'd0, Y_ZERO};
    localparam logic [63:0] T_LIMIT   = 64'h7FFF_FFFF;

    logic signed [31:0] mean_reg;
    logic [30:0]        width_reg;
    logic [23:0]        lalpha_reg, lpower_reg, ralpha_reg, rpower_reg;

    shape_beat_t expected_shapes[$];

    function automatic logic [63:0] mul_hi32(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[95:32];
    endfunction

    // Base-2 exponent of exp(-m*m/2), Q32.
    function automatic logic [63:0] gauss_exp2(logic [63:0] m);
        logic [63:0] h;
        h = m * m;
        if (h >= (64'd64 << (2 * FB)))
            return Y_LIMIT;
        return mul_hi32(h >> (2 * FB - 31), LOG2E_FIX);
    endfunction

    function automatic logic [63:0] log2_fix(logic [63:0] x);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 63;
        frac = 0;
        while (p > 0 && x[p] == 1'b0)
            p--;
        m = (p >= 31) ? (x >> (p - 31)) : (x << (31 - p));
        for (int i = 0; i < 32; i++)
        begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32))
            begin
                m = m >> 1;
                frac[31 - i] = 1'b1;
            end
        end
        return (64'(p) << 32) | frac;
    endfunction

    // 2^-y in Q1.31 through a Taylor sum of e^z.
    function automatic logic [31:0] exp2_neg(logic [63:0] y);
        logic [63:0] s, z, term, sum, res;
        int          sh;
        if (y >= Y_LIMIT)
            return 32'd0;
        if (y == 0)
            return ONE_Q31;
        s = (64'd1 << 32) - {32'd0, y[31:0]};
        z = (s * {32'd0, LN2_Q32}) >> 32;
        term = 64'd1 << 32;
        sum = term;
        for (int i = 1; i <= TAYLOR_TERMS; i++)
        begin
            term = ((term * z) >> 32) / 64'(i);
            sum += term;
        end
        sh = int'(y >> 32) + 2;
        res = (sum + (64'd1 << (sh - 1))) >> sh;
        return (res > 64'(ONE_Q31)) ? ONE_Q31 : res[31:0];
    endfunction

    function automatic logic [31:0] tail_shape(logic [63:0] tmag, logic [63:0] a,
                                               logic [63:0] n);
        logic [63:0] y, v, w, lw, lv, d, s;
        y = gauss_exp2(a);
        if (n != 0 && tmag > a)
        begin
            v = n << FB;
            w = v + (tmag - a) * a;
            lw = log2_fix(w);
            lv = log2_fix(v);
            d = (lw > lv) ? lw - lv : 64'd0;
            s = y + ((n * d) >> FB);
            y = (s < y) ? '1 : s;
        end
        return exp2_neg(y);
    endfunction

    function automatic shape_beat_t predict_shape(sample_beat_t b);
        longint signed d;
        logic          neg;
        logic [63:0]   mag, w, q, r, tmag, a, n;
        shape_beat_t   o;
        d = longint'(b.sample_value) - longint'(b.sample_offset) - longint'(mean_reg);
        neg = d < 0;
        mag = neg ? 64'(-d) : 64'(d);
        w = (width_reg != 0) ? 64'(width_reg) : 64'd1;
        q = mag / w;
        r = mag % w;
        a = neg ? 64'(lalpha_reg) : 64'(ralpha_reg);
        n = neg ? 64'(lpower_reg) : 64'(rpower_reg);
        if (q >= (64'd1 << 15))
            tmag = T_LIMIT;
        else
        begin
            tmag = (q << FB) + (r << FB) / w;
            if (tmag > T_LIMIT)
                tmag = T_LIMIT;
        end
        if (tmag <= a)
        begin
            o.shape_value = exp2_neg(gauss_exp2(tmag));
            o.region = REGION_CORE;
        end
        else
        begin
            o.shape_value = tail_shape(tmag, a, n);
            o.region = neg ? REGION_LEFT : REGION_RIGHT;
        end
        return o;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        shape_beat_t want;
        if (!rst_n)
        begin
            mean_reg <= 0;
            width_reg <= 31'd65536;
            lalpha_reg <= 24'd65536;
            lpower_reg <= 24'd131072;
            ralpha_reg <= 24'd65536;
            rpower_reg <= 24'd131072;
            errors <= 0;
            pending <= 0;
            checked <= 0;
            expected_shapes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_PEAK_MEAN:   mean_reg <= cfg_data;
                    CFG_CORE_WIDTH:  width_reg <= cfg_data[30:0];
                    CFG_LEFT_ALPHA:  lalpha_reg <= cfg_data[23:0];
                    CFG_LEFT_POWER:  lpower_reg <= cfg_data[23:0];
                    CFG_RIGHT_ALPHA: ralpha_reg <= cfg_data[23:0];
                    CFG_RIGHT_POWER: rpower_reg <= cfg_data[23:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_shapes.push_back(predict_shape(s_data));
            if (r_valid && r_ready)
            begin
                if (expected_shapes.size() == 0)
                begin
                    if (errors < 10)
                        $display("checker: unexpected shape beat %h region %0d",
                                 r_data.shape_value, r_data.region);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_shapes.pop_front();
                    if (want.shape_value !== r_data.shape_value
                        || want.region !== r_data.region)
                    begin
                        if (errors < 10)
                            $display("checker: beat %0d expected %h/%0d got %h/%0d",
                                     checked, want.shape_value, want.region,
                                     r_data.shape_value, r_data.region);
                        errors <= errors + 1;
                    end
                end
                checked <= checked + 1;
            end
            pending <= expected_shapes.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams samples through the Crystal Ball evaluator under several register
// settings and idle patterns; a checker beside the block predicts every shape
// beat and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;
    import dcb_pkg::*;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_HI = 3'd7;
    localparam int PHASES      = 8;
    localparam int RANDOM_BEATS = 90;
    // The pipeline is 146 stages deep; the quiet stretch lets it empty.
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT  = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int   errors, pending, checked;
    int   tx_idle_pct, rx_idle_pct;
    int   quiet_cycles;
    int   sent;

    dcb_stream_if #(.payload_t(sample_beat_t)) samples ();
    dcb_stream_if #(.payload_t(shape_beat_t))  results ();

    double_crystal_ball_eval i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .results   (results),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dcb_shape_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (samples.valid),
        .s_ready   (samples.ready),
        .s_data    (samples.data),
        .r_valid   (results.valid),
        .r_ready   (results.ready),
        .r_data    (results.data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The result side stalls at random with the share that the current phase
    // sets; with a zero share it takes every beat.
    always @(posedge clk)
    begin
        results.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // The watchdog ends a run that stops moving: any accepted beat on either
    // channel restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (samples.valid && samples.ready) || (results.valid && results.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    // Sends one sample beat, first holding valid low for a random number of
    // cycles, and returns at the edge that accepts it.
    task automatic send_sample(input logic [31:0] value, input logic [31:0] offset);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(posedge clk);
        end
        samples.valid <= 1'b1;
        samples.data.sample_value <= value;
        samples.data.sample_offset <= offset;
        @(posedge clk);
        while (!samples.ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Registers change only once every predicted beat has come back and the
    // pipeline has had time to empty.
    task automatic drain_pipeline();
        samples.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] s[6]);
        write_reg(CFG_PEAK_MEAN, s[0]);
        write_reg(CFG_CORE_WIDTH, s[1]);
        write_reg(CFG_LEFT_ALPHA, s[2]);
        write_reg(CFG_LEFT_POWER, s[3]);
        write_reg(CFG_RIGHT_ALPHA, s[4]);
        write_reg(CFG_RIGHT_POWER, s[5]);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] settings[6];
        logic [31:0] mean_now;
        logic [31:0] offset, delta;
        samples.valid = 1'b0;
        samples.data = '0;
        results.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        tx_idle_pct = 23;
        rx_idle_pct = 48;
        sent = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset settings (mean 0, width 1.0, alphas
        // 1.0, powers 2.0): the core edges at t = +-1, just past them into
        // each tail, and the widest distances that the fields allow, which
        // saturate |t|.
        send_sample(32'h0000_0000, 32'h0000_0000);
        send_sample(32'h0001_0000, 32'h0000_0000);
        send_sample(32'h0001_0001, 32'h0000_0000);
        send_sample(32'hFFFF_0000, 32'h0000_0000);
        send_sample(32'hFFFE_FFFF, 32'h0000_0000);
        send_sample(32'h0002_0000, 32'h0000_0000);
        send_sample(32'hFF9C_0000, 32'h0000_0000);
        send_sample(32'h0000_8000, 32'hFFFF_8000);
        send_sample(32'h7FFF_FFFF, 32'h8000_0000);
        send_sample(32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000, 32'h0000_0000);
        send_sample(32'h7FFF_FFFF, 32'h0000_0000);
        send_sample(32'h0000_0000, 32'h8000_0000);
        send_sample(32'h0008_0000, 32'h0000_0000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // First the sender idles less than the receiver, then the other
            // way round, and the last phases run with no idling at all.
            tx_idle_pct = (ph < 3) ? 23 : (ph < 6) ? 48 : 0;
            rx_idle_pct = (ph < 3) ? 48 : (ph < 6) ? 23 : 0;
            drain_pipeline();
            case (ph)
                // Mean off zero, narrow core, uneven tails.
                0: settings = '{32'h0010_0000, 32'h0000_8000, 32'h0003_0000,
                               32'h0001_8000, 32'h0000_8000, 32'h000A_0000};
                // Extremes: most negative mean, widest core, largest left
                // alpha and power, smallest right ones.
                1: settings = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h00FF_FFFF,
                               32'h00FF_FFFF, 32'h0000_0001, 32'h0000_0001};
                // The opposite extremes.
                2: settings = '{32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001,
                               32'h0000_0001, 32'h00FF_FFFF, 32'h00FF_FFFF};
                // Zero width, zero alpha on the left and zero powers.
                3: settings = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                               32'h0000_0000, 32'h0002_0000, 32'h0000_0000};
                // Junk above the width of each register narrower than 32 bits must be dropped.
                4: settings = '{32'hFFFF_0000, 32'h8004_0000, 32'hAB02_8000,
                               32'hCD00_4000, 32'hEF01_0000, 32'h1240_0000};
                default:
                begin
                    settings[0] = $urandom;
                    settings[1] = $urandom_range(32'h0040_0000, 1);
                    settings[2] = $urandom_range(32'h0006_0000);
                    settings[3] = $urandom_range(32'h0020_0000);
                    settings[4] = $urandom_range(32'h0006_0000);
                    settings[5] = $urandom;
                end
            endcase
            load_settings(settings);
            mean_now = settings[0];

            // Most samples land within a random power of two of the mean,
            // so every region and the tail knees are reached; some are
            // fully random and mostly saturate.
            for (int i = 0; i < RANDOM_BEATS; i++)
            begin
                offset = ($urandom_range(1) != 0) ? $urandom : 32'd0;
                if ($urandom_range(7) == 0)
                    send_sample($urandom, offset);
                else
                begin
                    delta = $signed($urandom) >>> $urandom_range(31);
                    send_sample(mean_now + offset + delta, offset);
                end
            end
        end

        samples.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d samples over %0d register settings and three idle patterns;",
                 sent, PHASES + 1);
        $display("%0d shape beats checked, %0d mismatches.", checked, errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
